@@ hw/rtl/load_cell_tare_and_weight_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Load cell unit assertion macros
// Shorthand for clocked assertions sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_TARE_AND_WEIGHT_UNIT_ASSERT_SVH
`define LOAD_CELL_TARE_AND_WEIGHT_UNIT_ASSERT_SVH

// Same-cycle implication
`define LCTW_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("load cell unit assertion failed");

// Next-cycle implication
`define LCTW_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("load cell unit assertion failed");

`endif

@@ hw/rtl/lctw_pkg.sv @@
// ----------------------------------------------------------------------------
// Load cell package
// Widths, codes, reset values and shared types of the load cell unit.
// ----------------------------------------------------------------------------
package lctw_pkg;

   localparam int SAMPLE_W = 24;
   localparam int E_W      = 26;
   localparam int DX_W     = 25;
   localparam int MUL_W    = 27;
   localparam int ACC_W    = 54;
   localparam int WEIGHT_W = 32;

   // Opcodes
   localparam logic [1:0] OP_CONVERT = 2'd0;
   localparam logic [1:0] OP_TARE    = 2'd1;
   localparam logic [1:0] OP_LOAD    = 2'd2;

   // Result status codes
   localparam logic [1:0] STS_WEIGHT = 2'd0;
   localparam logic [1:0] STS_STABLE = 2'd1;
   localparam logic [1:0] STS_FAILED = 2'd2;

   // Register indexes
   localparam logic [2:0] CSR_POINT0_COUNT = 3'd0;
   localparam logic [2:0] CSR_POINT0_MASS  = 3'd4;

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 32'sh7FFFFFFF;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 32'sh80000000;

   localparam logic signed [SAMPLE_W-1:0] COUNT_RESET [4] =
      '{24'sd235469, 24'sd546061, 24'sd856428, 24'sd1477409};
   localparam logic signed [SAMPLE_W-1:0] MASS_RESET [4] =
      '{24'sd0, 24'sd12800, 24'sd25600, 24'sd51200};

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEL,
      S_MUL,
      S_DIV,
      S_PUT
   } state_type;

   typedef struct packed {
      logic                stable;
      logic                fail;
      logic [SAMPLE_W-1:0] spread;
   } tare_evt_type;

endpackage

@@ hw/rtl/lctw_divider.sv @@
// ----------------------------------------------------------------------------
// Load cell serial divider
// Signed restoring division, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module lctw_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [lctw_pkg::ACC_W-1:0]  dividend,
   input  logic signed [lctw_pkg::DX_W-1:0]   divisor,
   output logic                               done,
   output logic signed [lctw_pkg::ACC_W-1:0]  quotient
);
   import lctw_pkg::*;

   localparam int CNT_W = $clog2(ACC_W);

   logic                 busy_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 done_ff;
   logic                 neg_ff;
   logic [ACC_W-1:0]     dq_ff;
   logic [DX_W-1:0]      rem_ff;
   logic [DX_W-1:0]      dmag_ff;
   logic [DX_W:0]        rem_sh;
   logic [DX_W:0]        diff;
   logic                 ge;
   logic                 last;

   // Shift in one dividend bit and trial-subtract
   always_comb begin
      rem_sh = {rem_ff, dq_ff[ACC_W-1]};
      diff   = rem_sh - {1'b0, dmag_ff};
      ge     = rem_sh >= {1'b0, dmag_ff};
      last   = cnt_ff == CNT_W'(ACC_W - 1);
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath: load magnitudes, then iterate
   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff   <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
         dmag_ff <= divisor[DX_W-1] ? DX_W'(-divisor) : DX_W'(divisor);
         neg_ff  <= dividend[ACC_W-1] ^ divisor[DX_W-1];
         rem_ff  <= '0;
      end else if (busy_ff) begin
         dq_ff  <= {dq_ff[ACC_W-2:0], ge};
         rem_ff <= ge ? diff[DX_W-1:0] : rem_sh[DX_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(dq_ff) : $signed(dq_ff);

endmodule

@@ hw/rtl/lctw_tare.sv @@
// ----------------------------------------------------------------------------
// Load cell tare tracker
// Median of three, window accumulation, spread check and round counting.
// ----------------------------------------------------------------------------
module lctw_tare #(
   parameter int TARE_WINDOW   = 32,
   parameter int TARE_ROUNDS   = 10,
   parameter int STABLE_SPREAD = 300,
   parameter int SUM_W         = 30
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic signed [lctw_pkg::SAMPLE_W-1:0] sample,
   output lctw_pkg::tare_evt_type               evt,
   output logic signed [SUM_W-1:0]              sum
);
   import lctw_pkg::*;

   localparam int CNT_W = $clog2(TARE_WINDOW + 1);
   localparam int RND_W = $clog2(TARE_ROUNDS + 1);

   logic signed [SAMPLE_W-1:0] store_ff [2];
   logic [1:0]                 fill_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SAMPLE_W-1:0] min_ff;
   logic signed [SAMPLE_W-1:0] max_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [RND_W-1:0]           round_ff;

   logic signed [SAMPLE_W-1:0] med;
   logic signed [SAMPLE_W-1:0] lo;
   logic signed [SAMPLE_W-1:0] hi;
   logic signed [SAMPLE_W-1:0] mid;
   logic signed [SUM_W-1:0]    sum_new;
   logic signed [SAMPLE_W-1:0] min_new;
   logic signed [SAMPLE_W-1:0] max_new;
   logic [CNT_W-1:0]           count_new;
   logic [RND_W-1:0]           round_new;
   logic signed [SAMPLE_W:0]   spread_v;
   logic                       triplet;
   logic                       full;
   logic                       stable;
   logic                       give_up;

   // Median of the stored pair and this sample, then the window update
   always_comb begin
      lo        = (store_ff[0] < store_ff[1]) ? store_ff[0] : store_ff[1];
      hi        = (store_ff[0] < store_ff[1]) ? store_ff[1] : store_ff[0];
      mid       = (hi < sample) ? hi : sample;
      med       = (lo > mid) ? lo : mid;
      sum_new   = sum_ff + SUM_W'(med);
      min_new   = (med < min_ff) ? med : min_ff;
      max_new   = (med > max_ff) ? med : max_ff;
      count_new = count_ff + 1'b1;
      round_new = round_ff + 1'b1;
      spread_v  = (SAMPLE_W+1)'(max_new) - (SAMPLE_W+1)'(min_new);
      triplet   = step && (fill_ff == 2'd2);
      full      = count_new == CNT_W'(TARE_WINDOW);
      stable    = spread_v < $signed((SAMPLE_W+1)'(STABLE_SPREAD));
      give_up   = round_new == RND_W'(TARE_ROUNDS);
   end

   assign evt.stable = triplet && full && stable;
   assign evt.fail   = triplet && full && !stable && give_up;
   assign evt.spread = spread_v[SAMPLE_W-1:0];
   assign sum        = sum_new;

   // Hold the first two samples of a triplet
   always_ff @(posedge clock) begin
      if (step && !fill_ff[1]) begin
         store_ff[fill_ff[0]] <= sample;
      end
   end

   // Advance the window and round state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         sum_ff   <= '0;
         min_ff   <= {1'b0, {(SAMPLE_W-1){1'b1}}};
         max_ff   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
         count_ff <= '0;
         round_ff <= '0;
      end else if (step) begin
         if (!fill_ff[1]) begin
            fill_ff <= fill_ff + 1'b1;
         end else begin
            fill_ff <= '0;
            if (!full) begin
               sum_ff   <= sum_new;
               min_ff   <= min_new;
               max_ff   <= max_new;
               count_ff <= count_new;
            end else begin
               sum_ff   <= '0;
               min_ff   <= {1'b0, {(SAMPLE_W-1){1'b1}}};
               max_ff   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
               count_ff <= '0;
               if (stable || give_up) begin
                  round_ff <= '0;
               end else begin
                  round_ff <= round_new;
               end
            end
         end
      end
   end

endmodule

@@ hw/rtl/load_cell_tare_and_weight_unit.sv @@
// ----------------------------------------------------------------------------
// Load cell tare and weight unit
// Converts load cell counts to weight over four calibration points and
// determines the tare offset from windows of median-filtered samples.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Load offset, unused opcodes and tare
// samples that close no window are handled in the idle state. A convert
// steps through forming the shifted count, choosing the segment, the
// bit-serial multiply-accumulate of the numerator, the shared serial
// divider, which yields one quotient bit per cycle, and handing the
// result to the output register; a convert on a zero-width segment skips the
// multiply and the divide. A tare sample that closes a stable window runs in
// the same divider; a failed tare goes straight to the output hand-off. A
// finished result waits in the output register while the next transaction is
// accepted.
module load_cell_tare_and_weight_unit #(
   parameter int TARE_WINDOW   = 32,
   parameter int TARE_ROUNDS   = 10,
   parameter int STABLE_SPREAD = 300
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_opcode,
   input  logic signed [lctw_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic signed [lctw_pkg::WEIGHT_W-1:0] rsp_weight,
   output logic signed [lctw_pkg::SAMPLE_W-1:0] rsp_offset,
   output logic [lctw_pkg::SAMPLE_W-1:0]        rsp_spread,
   input  logic                                 csr_we,
   input  logic [2:0]                           csr_index,
   input  logic [lctw_pkg::SAMPLE_W-1:0]        csr_wdata
);
   import lctw_pkg::*;

   localparam int SUM_W = SAMPLE_W + $clog2(TARE_WINDOW + 1);
   localparam int K_W   = $clog2(MUL_W);

   state_type                  state_ff, state_in;
   logic signed [SAMPLE_W-1:0] cnt_ff [4];
   logic signed [SAMPLE_W-1:0] mass_ff [4];
   logic signed [SAMPLE_W-1:0] offset_ff;
   logic signed [E_W-1:0]      e_ff;
   logic signed [ACC_W-1:0]    a_ff, c_ff, acc_ff;
   logic signed [MUL_W-1:0]    b_ff, d_ff;
   logic [K_W-1:0]             k_ff;
   logic signed [DX_W-1:0]     dx_ff;
   logic                       for_tare_ff;
   logic [SAMPLE_W-1:0]        spread_ff;
   logic [1:0]                 res_status_ff;
   logic signed [WEIGHT_W-1:0] res_weight_ff;
   logic                       rsp_valid_ff;
   logic [1:0]                 rsp_status_ff;
   logic signed [WEIGHT_W-1:0] rsp_weight_ff;
   logic signed [SAMPLE_W-1:0] rsp_offset_ff;
   logic [SAMPLE_W-1:0]        rsp_spread_ff;

   logic                       accept;
   logic                       tare_step;
   tare_evt_type               tare_evt;
   logic signed [SUM_W-1:0]    tare_sum;
   logic                       div_start;
   logic signed [ACC_W-1:0]    div_dvd;
   logic signed [DX_W-1:0]     div_dvs;
   logic                       div_done;
   logic signed [ACC_W-1:0]    div_q;
   logic signed [WEIGHT_W-1:0] sat_weight;
   logic signed [E_W-1:0]      ce [4];
   logic [1:0]                 lo_i, hi_i, base_i;
   logic signed [DX_W-1:0]     dx, dy;
   logic signed [MUL_W-1:0]    dd;
   logic signed [ACC_W-1:0]    ta, tc, acc_next;
   logic                       mul_last;
   logic                       rsp_load;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign tare_step = accept && (req_opcode == OP_TARE);

   lctw_tare #(
      .TARE_WINDOW   (TARE_WINDOW),
      .TARE_ROUNDS   (TARE_ROUNDS),
      .STABLE_SPREAD (STABLE_SPREAD),
      .SUM_W         (SUM_W)
   ) u_tare (
      .clock  (clock),
      .reset  (reset),
      .step   (tare_step),
      .sample (req_sample),
      .evt    (tare_evt),
      .sum    (tare_sum)
   );

   // Segment choice and operands
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ce[i] = E_W'(cnt_ff[i]);
      end
      lo_i   = 2'd2;
      hi_i   = 2'd3;
      base_i = 2'd3;
      if (e_ff >= ce[0] && e_ff <= ce[1]) begin
         lo_i = 2'd0; hi_i = 2'd1; base_i = 2'd0;
      end else if (e_ff >= ce[1] && e_ff <= ce[2]) begin
         lo_i = 2'd1; hi_i = 2'd2; base_i = 2'd1;
      end else if (e_ff >= ce[2] && e_ff <= ce[3]) begin
         lo_i = 2'd2; hi_i = 2'd3; base_i = 2'd2;
      end else if (e_ff < ce[0]) begin
         lo_i = 2'd0; hi_i = 2'd1; base_i = 2'd0;
      end
      dx = DX_W'(cnt_ff[hi_i]) - DX_W'(cnt_ff[lo_i]);
      dy = DX_W'(mass_ff[hi_i]) - DX_W'(mass_ff[lo_i]);
      dd = MUL_W'(e_ff) - MUL_W'(cnt_ff[base_i]);
   end

   // One multiplier bit of each product per cycle; top bit weighs negative
   always_comb begin
      mul_last = k_ff == K_W'(MUL_W - 1);
      ta       = b_ff[0] ? a_ff : '0;
      tc       = d_ff[0] ? c_ff : '0;
      if (mul_last) begin
         ta = -ta;
         tc = -tc;
      end
      acc_next = acc_ff + ta + tc;
   end

   // Divider operands
   always_comb begin
      div_start = 1'b0;
      div_dvd   = acc_next;
      div_dvs   = dx_ff;
      if (state_ff == S_IDLE) begin
         div_start = tare_step && tare_evt.stable;
         div_dvd   = ACC_W'(tare_sum);
         div_dvs   = DX_W'(TARE_WINDOW);
      end else if (state_ff == S_MUL) begin
         div_start = mul_last;
      end
   end

   lctw_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   // Saturate the quotient to the weight range
   always_comb begin
      if (div_q > ACC_W'(WEIGHT_MAX)) begin
         sat_weight = WEIGHT_MAX;
      end else if (div_q < ACC_W'(WEIGHT_MIN)) begin
         sat_weight = WEIGHT_MIN;
      end else begin
         sat_weight = div_q[WEIGHT_W-1:0];
      end
   end

   assign rsp_load = (state_ff == S_PUT) && (!rsp_valid_ff || !rsp_stall);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_opcode == OP_CONVERT) begin
               state_in = S_SEL;
            end else if (tare_step && tare_evt.stable) begin
               state_in = S_DIV;
            end else if (tare_step && tare_evt.fail) begin
               state_in = S_PUT;
            end
         end
         S_SEL: begin
            state_in = (dx == '0) ? S_PUT : S_MUL;
         end
         S_MUL: begin
            if (mul_last) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Calibration registers and tare offset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i]  <= COUNT_RESET[i];
            mass_ff[i] <= MASS_RESET[i];
         end
         offset_ff <= '0;
      end else begin
         if (csr_we) begin
            if (csr_index < CSR_POINT0_MASS) begin
               cnt_ff[csr_index[1:0]] <= csr_wdata;
            end else begin
               mass_ff[csr_index[1:0]] <= csr_wdata;
            end
         end
         if (accept && req_opcode == OP_LOAD) begin
            offset_ff <= req_sample;
         end else if (state_ff == S_DIV && div_done && for_tare_ff) begin
            offset_ff <= div_q[SAMPLE_W-1:0];
         end
      end
   end

   // Convert and tare datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (accept && req_opcode == OP_CONVERT) begin
               e_ff        <= E_W'(req_sample) - E_W'(offset_ff) + E_W'(cnt_ff[0]);
               spread_ff   <= '0;
               for_tare_ff <= 1'b0;
            end else if (tare_step) begin
               spread_ff     <= tare_evt.spread;
               for_tare_ff   <= 1'b1;
               res_status_ff <= STS_FAILED;
               res_weight_ff <= '0;
            end
         end
         S_SEL: begin
            a_ff          <= ACC_W'(mass_ff[base_i]);
            b_ff          <= MUL_W'(dx);
            c_ff          <= ACC_W'(dy);
            d_ff          <= dd;
            dx_ff         <= dx;
            acc_ff        <= '0;
            k_ff          <= '0;
            res_status_ff <= STS_WEIGHT;
            res_weight_ff <= WEIGHT_W'(mass_ff[lo_i]);
         end
         S_MUL: begin
            acc_ff <= acc_next;
            a_ff   <= a_ff <<< 1;
            c_ff   <= c_ff <<< 1;
            b_ff   <= b_ff >>> 1;
            d_ff   <= d_ff >>> 1;
            k_ff   <= k_ff + 1'b1;
         end
         S_DIV: begin
            if (div_done) begin
               res_status_ff <= for_tare_ff ? STS_STABLE : STS_WEIGHT;
               res_weight_ff <= for_tare_ff ? '0 : sat_weight;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register: load when free, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_weight_ff <= res_weight_ff;
         rsp_offset_ff <= offset_ff;
         rsp_spread_ff <= spread_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_weight = rsp_weight_ff;
   assign rsp_offset = rsp_offset_ff;
   assign rsp_spread = rsp_spread_ff;

endmodule

@@ hw/rtl/lctw_checker.sv @@
// ----------------------------------------------------------------------------
// Load cell unit checker
// Port-level assertions on the load cell unit, attached by bind.
// ----------------------------------------------------------------------------
`include "load_cell_tare_and_weight_unit_assert.svh"

module lctw_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [1:0]                           req_opcode,
   input logic signed [lctw_pkg::SAMPLE_W-1:0] req_sample,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [1:0]                           rsp_status,
   input logic signed [lctw_pkg::WEIGHT_W-1:0] rsp_weight,
   input logic signed [lctw_pkg::SAMPLE_W-1:0] rsp_offset,
   input logic [lctw_pkg::SAMPLE_W-1:0]        rsp_spread,
   input logic                                 csr_we,
   input logic [2:0]                           csr_index,
   input logic [lctw_pkg::SAMPLE_W-1:0]        csr_wdata
);
   import lctw_pkg::*;

   // A stalled result holds
   `LCTW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_weight) && $stable(rsp_status))

   // Weight results carry no spread
   `LCTW_ASSERT_NOW(a_weight_spread, rsp_valid && rsp_status == STS_WEIGHT, rsp_spread == '0)

   // Tare results carry no weight
   `LCTW_ASSERT_NOW(a_tare_weight, rsp_valid && rsp_status != STS_WEIGHT, rsp_weight == '0)

   // Only defined status codes are shown
   `LCTW_ASSERT_NOW(a_status_code, rsp_valid, rsp_status == STS_WEIGHT || rsp_status == STS_STABLE || rsp_status == STS_FAILED)

   // A convert keeps the input busy in the following cycle
   `LCTW_ASSERT_NEXT(a_convert_busy, req_valid && !req_stall && req_opcode == OP_CONVERT, req_stall)

endmodule

bind load_cell_tare_and_weight_unit lctw_checker u_lctw_checker (.*);

@@ bench/load_cell_tare_and_weight_checker.sv @@
// ----------------------------------------------------------------------------
// Load cell unit checker
// Watches the register port and both channels of the load cell unit, keeps
// its own copy of calibration and tare state, predicts each result that an
// accepted transaction yields and checks each delivered result field by field.
// ----------------------------------------------------------------------------
module load_cell_tare_and_weight_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [1:0]                           req_opcode,
   input  logic signed [lctw_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [1:0]                           rsp_status,
   input  logic signed [lctw_pkg::WEIGHT_W-1:0] rsp_weight,
   input  logic signed [lctw_pkg::SAMPLE_W-1:0] rsp_offset,
   input  logic [lctw_pkg::SAMPLE_W-1:0]        rsp_spread,
   input  logic                                 csr_we,
   input  logic [2:0]                           csr_index,
   input  logic [lctw_pkg::SAMPLE_W-1:0]        csr_wdata,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   n_weights,
   output int                                   n_stable,
   output int                                   n_failed
);
   import lctw_pkg::*;

   localparam int WINDOW_LEN   = 32;
   localparam int ROUND_LIMIT  = 10;
   localparam int SPREAD_LIMIT = 300;

   typedef struct {
      logic [1:0]                 status;
      logic signed [WEIGHT_W-1:0] weight;
      logic signed [SAMPLE_W-1:0] offset;
      logic [SAMPLE_W-1:0]        spread;
   } lc_result_type;

   lc_result_type expected_results[$];

   // Calibration table and tare progress
   longint      cal_count[4];
   longint      cal_mass[4];
   longint      tare_off;
   longint      triple[2];
   int          triple_fill;
   longint      med_sum;
   longint      med_lo;
   longint      med_hi;
   int          med_cnt;
   int          unstable_rounds;

   assign pending = expected_results.size();

   // Interpolate over one segment, anchored at point base
   function automatic longint segment_weight(int lo, int hi, int base, longint e);
      longint dx;
      longint dy;
      dx = cal_count[hi] - cal_count[lo];
      dy = cal_mass[hi] - cal_mass[lo];
      if (dx == 0) return cal_mass[lo];
      return (cal_mass[base] * dx + dy * (e - cal_count[base])) / dx;
   endfunction

   function automatic logic signed [WEIGHT_W-1:0] weigh(longint s);
      longint e;
      longint w;
      bit     hit;
      e   = s - tare_off + cal_count[0];
      w   = 0;
      hit = 0;
      for (int i = 0; i < 3; i++) begin
         if (!hit && e >= cal_count[i] && e <= cal_count[i+1]) begin
            w   = segment_weight(i, i + 1, i, e);
            hit = 1;
         end
      end
      if (!hit) begin
         if (e < cal_count[0]) w = segment_weight(0, 1, 0, e);
         else w = segment_weight(2, 3, 3, e);
      end
      if (w > longint'(WEIGHT_MAX)) w = longint'(WEIGHT_MAX);
      if (w < longint'(WEIGHT_MIN)) w = longint'(WEIGHT_MIN);
      return w[WEIGHT_W-1:0];
   endfunction

   function automatic void clear_window();
      med_sum = 0;
      med_lo  = 8388607;
      med_hi  = -8388608;
      med_cnt = 0;
   endfunction

   // Advance the tare filter by one sample; queue a result on a stable window or a failed tare
   function automatic void tare_sample(longint s);
      longint        lo;
      longint        hi;
      longint        m;
      longint        spr;
      lc_result_type r;
      if (triple_fill < 2) begin
         triple[triple_fill] = s;
         triple_fill++;
         return;
      end
      triple_fill = 0;
      lo = (triple[0] < triple[1]) ? triple[0] : triple[1];
      hi = (triple[0] < triple[1]) ? triple[1] : triple[0];
      m  = (hi < s) ? hi : s;
      m  = (lo > m) ? lo : m;
      med_sum += m;
      if (m < med_lo) med_lo = m;
      if (m > med_hi) med_hi = m;
      med_cnt++;
      if (med_cnt < WINDOW_LEN) return;
      spr = med_hi - med_lo;
      if (spr < SPREAD_LIMIT) begin
         tare_off = med_sum / WINDOW_LEN;
         clear_window();
         unstable_rounds = 0;
         r.status = STS_STABLE;
      end else begin
         clear_window();
         unstable_rounds++;
         if (unstable_rounds < ROUND_LIMIT) return;
         unstable_rounds = 0;
         r.status = STS_FAILED;
      end
      r.weight = '0;
      r.offset = tare_off[SAMPLE_W-1:0];
      r.spread = spr[SAMPLE_W-1:0];
      expected_results.push_back(r);
   endfunction

   task automatic report(string field, longint got, longint want);
      $display("%0t: result mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      n_weights  = 0;
      n_stable   = 0;
      n_failed   = 0;
   end

   always @(posedge clock) begin
      lc_result_type r;
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            cal_count[i] = COUNT_RESET[i];
            cal_mass[i]  = MASS_RESET[i];
         end
         tare_off        = 0;
         triple_fill     = 0;
         unstable_rounds = 0;
         clear_window();
         expected_results.delete();
      end else begin
         // Compare the delivered result first, it belongs to an older transaction
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result delivered with nothing outstanding", $time);
               fail_count++;
            end else begin
               r = expected_results.pop_front();
               if (rsp_status != r.status) report("status", rsp_status, r.status);
               if (rsp_weight != r.weight) report("weight", rsp_weight, r.weight);
               if (rsp_offset != r.offset) report("offset", rsp_offset, r.offset);
               if (rsp_spread != r.spread) report("spread", rsp_spread, r.spread);
               case (rsp_status)
                  STS_WEIGHT: n_weights++;
                  STS_STABLE: n_stable++;
                  default: n_failed++;
               endcase
            end
         end
         if (csr_we) begin
            if (csr_index < CSR_POINT0_MASS)
               cal_count[csr_index] = longint'($signed(csr_wdata));
            else
               cal_mass[csr_index - CSR_POINT0_MASS] = longint'($signed(csr_wdata));
         end
         if (req_valid && !req_stall) begin
            case (req_opcode)
               OP_CONVERT: begin
                  r.status = STS_WEIGHT;
                  r.weight = weigh(req_sample);
                  r.offset = tare_off[SAMPLE_W-1:0];
                  r.spread = '0;
                  expected_results.push_back(r);
               end
               OP_LOAD: tare_off = req_sample;
               OP_TARE: tare_sample(req_sample);
               default: ;
            endcase
         end
      end
   end

endmodule

@@ bench/tb_load_cell_tare_and_weight_unit.sv @@
// ----------------------------------------------------------------------------
// Load cell unit testbench
// Drives converts, tare samples, offset loads and unused opcodes through the
// load cell unit under several calibration tables, with random idling on
// both channels; a checker beside the unit predicts and compares results.
// ----------------------------------------------------------------------------
module tb_load_cell_tare_and_weight_unit;
   import lctw_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [1:0]                 req_opcode;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [1:0]                 rsp_status;
   logic signed [WEIGHT_W-1:0] rsp_weight;
   logic signed [SAMPLE_W-1:0] rsp_offset;
   logic [SAMPLE_W-1:0]        rsp_spread;
   logic                       csr_we;
   logic [2:0]                 csr_index;
   logic [SAMPLE_W-1:0]        csr_wdata;

   int  fail_count;
   int  pending;
   int  n_weights;
   int  n_stable;
   int  n_failed;
   int  n_sent;
   bit  idling_on;
   bit  hold_request;

   load_cell_tare_and_weight_unit dut (.*);

   load_cell_tare_and_weight_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Ceiling on run time
   initial begin
      #8000000;
      $display("tb_load_cell_tare_and_weight_unit NOT OK");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall    <= 1'b1;
            hold_request = 1'b0;
            repeat (400) @(negedge clock);
         end
         rsp_stall <= idling_on && ($urandom_range(99) < 30);
      end
   end

   // Offer one transaction and hold it until accepted
   task automatic send_item(logic [1:0] op, logic [SAMPLE_W-1:0] value);
      while (idling_on && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      n_sent++;
   endtask

   // Drain all outstanding results, then let any silent work finish
   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic load_table(longint c0, longint c1, longint c2, longint c3,
                             longint m0, longint m1, longint m2, longint m3);
      longint vals[8];
      vals = '{c0, c1, c2, c3, m0, m1, m2, m3};
      settle();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_POINT0_COUNT + 3'(i);
         csr_wdata <= vals[i][SAMPLE_W-1:0];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] any_value();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         1: return 24'($urandom_range(2000000) - 500000);
         default: return 24'($urandom);
      endcase
   endfunction

   // Random mix: tare bursts around a base value, converts, loads, unused codes
   task automatic random_mix(int count);
      int     left;
      int     burst;
      int     noise;
      longint base;
      left = count;
      while (left > 0) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               burst = $urandom_range(100, 30);
               base  = longint'($signed(24'($urandom))) / 2;
               noise = $urandom_range(3) == 0 ? 4000 : 120;
               for (int k = 0; k < burst; k++) begin
                  if ($urandom_range(19) == 0) send_item(OP_CONVERT, any_value());
                  send_item(OP_TARE, 24'(base + $urandom_range(2 * noise) - noise));
               end
               left -= burst;
            end
            4: begin
               send_item(OP_LOAD, $urandom_range(1) ? any_value() : 24'($urandom_range(1000)));
               left--;
            end
            5: begin
               send_item($urandom_range(1) ? OP_UNUSED : OP_TARE, any_value());
               left--;
            end
            default: begin
               send_item(OP_CONVERT, any_value());
               left--;
            end
         endcase
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_opcode   = OP_CONVERT;
      req_sample   = '0;
      csr_we       = 1'b0;
      csr_index    = CSR_POINT0_COUNT;
      csr_wdata    = '0;
      idling_on    = 1'b1;
      hold_request = 1'b0;
      n_sent       = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Power-on table, written back explicitly
      load_table(235469, 546061, 856428, 1477409, 0, 12800, 25600, 51200);
      send_item(OP_CONVERT, 24'h000000);
      send_item(OP_CONVERT, 24'h7FFFFF);
      send_item(OP_CONVERT, 24'h800000);
      send_item(OP_CONVERT, 24'd300000);
      send_item(OP_CONVERT, 24'd546061 - 24'd235469);
      send_item(OP_CONVERT, 24'd2000000);
      send_item(OP_LOAD, 24'h7FFFFF);
      send_item(OP_CONVERT, 24'h800000);
      send_item(OP_CONVERT, 24'h7FFFFF);
      send_item(OP_LOAD, 24'h800000);
      send_item(OP_CONVERT, 24'h7FFFFF);
      send_item(OP_CONVERT, 24'h000000);
      send_item(OP_UNUSED, 24'h5A5A5A);
      send_item(OP_UNUSED, 24'hA5A5A5);
      send_item(OP_LOAD, 24'h000000);
      send_item(OP_TARE, 24'd100);
      send_item(OP_TARE, 24'd50);
      send_item(OP_CONVERT, 24'd10);
      send_item(OP_TARE, 24'd75);

      // Stop draining results while converts keep coming
      hold_request = 1'b1;
      for (int k = 0; k < 8; k++) send_item(OP_CONVERT, any_value());
      random_mix(170);

      // Extreme, steep and inverted table; no idling anywhere
      load_table(-8388608, -100, 100, 8388607, 8388607, -8388608, 8388607, -8388608);
      idling_on = 1'b0;
      random_mix(170);
      idling_on = 1'b1;

      // Every segment of zero width
      load_table(1000, 1000, 1000, 1000, -5000, 7000, 9000, -3);
      random_mix(160);

      // Narrow table to drive saturation; noisy tare until the retry limit trips
      load_table(0, 1, 2, 3, -8388608, 8388607, -8388608, 8388607);
      for (int k = 0; k < 960; k++)
         send_item(OP_TARE, 24'($urandom));
      random_mix(80);

      // Random, possibly unordered, table
      load_table(longint'($signed(24'($urandom))), longint'($signed(24'($urandom))),
                 longint'($signed(24'($urandom))), longint'($signed(24'($urandom))),
                 longint'($signed(24'($urandom))), longint'($signed(24'($urandom))),
                 longint'($signed(24'($urandom))), longint'($signed(24'($urandom))));
      random_mix(160);

      // Drain with a bound, then give the verdict
      req_valid <= 1'b0;
      for (int k = 0; k < 20000 && pending != 0; k++) @(negedge clock);
      repeat (150) @(negedge clock);
      $display("Sent %0d transactions over five calibration tables.", n_sent);
      $display("Checked %0d weights, %0d stable tares, %0d failed tares.",
               n_weights, n_stable, n_failed);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_load_cell_tare_and_weight_unit OK");
      end else begin
         $display("tb_load_cell_tare_and_weight_unit NOT OK");
      end
      $finish;
   end

endmodule

@@ load_cell_tare_and_weight_unit.f @@
+incdir+hw/rtl
hw/rtl/lctw_pkg.sv
hw/rtl/lctw_divider.sv
hw/rtl/lctw_tare.sv
hw/rtl/load_cell_tare_and_weight_unit.sv
hw/rtl/lctw_checker.sv
bench/load_cell_tare_and_weight_checker.sv
bench/tb_load_cell_tare_and_weight_unit.sv
